// File: hw/rtl/bcdrtc_pkg.sv
package bcdrtc_pkg;

  // NVRAM size and address width
  localparam int NVRAM_BYTES = 64;
  localparam int RAM_AW      = (NVRAM_BYTES > 1) ? $clog2(NVRAM_BYTES) : 1;

  // Prescaler and rate register widths
  localparam int TPS_W = 27;
  localparam int PRE_W = 28;
  localparam logic [PRE_W-1:0] PRESCALE_MAX = 28'h0FF_FFFF | 28'hF00_0000;
  localparam logic [TPS_W-1:0] TPS_RESET    = 27'd8000000;

  // Operation codes
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;

  // Register addresses
  localparam logic [7:0] REG_SEC   = 8'h00;
  localparam logic [7:0] REG_MIN   = 8'h01;
  localparam logic [7:0] REG_HOUR  = 8'h02;
  localparam logic [7:0] REG_WDAY  = 8'h03;
  localparam logic [7:0] REG_DAY   = 8'h04;
  localparam logic [7:0] REG_MONTH = 8'h05;
  localparam logic [7:0] REG_YEAR  = 8'h06;
  localparam logic [7:0] RAM_BASE  = 8'h20;
  localparam logic [7:0] RAM_END   = 8'h60;

  // Output queue depth
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // One read item waiting for the NVRAM data
  typedef struct packed {
    logic       is_ram;
    logic       ram_ok;
    logic [7:0] data;
  } rd_stage_t;

  // Binary to BCD, tens digit kept to its low nibble
  function automatic logic [7:0] to_bcd(input logic [7:0] v);
    logic [15:0] prod;
    logic [7:0]  q;
    logic [7:0]  r;
    prod = {8'd0, v} * 16'd205;
    q    = {3'd0, prod[15:11]};
    r    = v - 8'(q * 8'd10);
    return {q[3:0], r[3:0]};
  endfunction

  // BCD to binary, nibbles taken as they are
  function automatic logic [7:0] from_bcd(input logic [7:0] v);
    return 8'({4'd0, v[7:4]} * 8'd10) + {4'd0, v[3:0]};
  endfunction

  // Days in a month; months outside 1-12 count as 31
  function automatic logic [7:0] month_days(input logic [7:0] m, input logic leap);
    logic [7:0] d;
    unique case (m)
      8'd2:                      d = leap ? 8'd29 : 8'd28;
      8'd4, 8'd6, 8'd9, 8'd11:   d = 8'd30;
      default:                   d = 8'd31;
    endcase
    return d;
  endfunction

endpackage

// File: hw/rtl/bcdrtc_in_if.sv
interface bcdrtc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [7:0]  addr;
  logic [7:0]  wdata;
  logic [15:0] cycles;

  modport source (output valid, output op, output addr, output wdata, output cycles,
                  input ready);
  modport sink   (input valid, input op, input addr, input wdata, input cycles,
                  output ready);
endinterface

// File: hw/rtl/bcdrtc_out_if.sv
interface bcdrtc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] rdata;

  modport source (output valid, output rdata, input ready);
  modport sink   (input valid, input rdata, output ready);
endinterface

// File: hw/rtl/bcd_rtc_calendar_registers_core.sv
// BCD real-time clock and calendar behind byte registers.
// in_if carries one item per handshake: a tick (cycles to add to the
// prescaler), a register read or a register write. Only a read gives a
// result item, the register byte, on out_if. cfg_we/cfg_wdata load the
// cycles-per-second rate; write it only while the block is idle.
// Every item takes effect at its accepting edge, so items can follow back
// to back at one per cycle while in_ready is high. A read result passes
// the registered NVRAM read port and then the output queue before it
// appears on out_if. A four-entry output queue parts the two sides.
// in_ready drops only when the queue plus the read in flight fill it,
// so a stalled receiver holds the block after four unread results;
// nothing is lost.
// Reset (rst_n low at a clock edge) stops the oscillator, sets 24 hour
// mode and battery enable, loads 00:00:00, weekday 1, 1 January of year 0,
// restores the default rate and marks all NVRAM bytes as zero through
// per-byte valid flags, so no clearing pass is needed.
module bcd_rtc_calendar_registers_core
  import bcdrtc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  bcdrtc_in_if.sink        in_if,
  bcdrtc_out_if.source     out_if,
  input  logic             cfg_we,
  input  logic [TPS_W-1:0] cfg_wdata
);

  // Clock and calendar state
  logic [TPS_W-1:0] tps_r;
  logic [PRE_W-1:0] pre_r,  pre_nxt;
  logic             run_r,  run_nxt;
  logic             m24_r,  m24_nxt;
  logic             bat_r,  bat_nxt;
  logic [7:0]       sec_r,  sec_nxt;
  logic [7:0]       min_r,  min_nxt;
  logic [7:0]       hour_r, hour_nxt;
  logic [7:0]       wday_r, wday_nxt;
  logic [7:0]       day_r,  day_nxt;
  logic [7:0]       mon_r,  mon_nxt;
  logic [7:0]       year_r, year_nxt;

  // Next-second values
  logic [7:0] ns_sec, ns_min, ns_hour, ns_wday, ns_day, ns_mon, ns_year;
  logic [7:0] sec_inc, min_inc, hour_inc, wday_inc, day_inc, mon_inc, year_inc;

  // Prescaler
  logic [PRE_W:0]   pre_sum;
  logic [PRE_W-1:0] pre_sat;
  logic [PRE_W:0]   pre_diff;
  logic             roll;

  // Handshake and decode
  logic       in_acc, rd_acc, wr_acc, tick_acc;
  logic [7:0] ram_off;
  logic       ram_hit;
  logic [RAM_AW-1:0] ram_idx;

  // NVRAM
  logic [7:0]             ram_mem [NVRAM_BYTES];
  logic [7:0]             ram_q_r;
  logic [NVRAM_BYTES-1:0] ram_vld_r;

  // Read path
  logic [7:0] rd_byte;
  logic [7:0] hr_v;
  logic       hr_pm;
  logic [7:0] wr_hour;
  logic       wr_pm;
  rd_stage_t  s1_r;
  logic       s1_v_r;
  logic [7:0] push_data;

  // Output queue
  logic [7:0]     q_mem_r [QDEPTH];
  logic [QAW-1:0] q_wp_r, q_rp_r;
  logic [QAW:0]   q_cnt_r;
  logic           push, pop;

  // Accept when the queue has room for every read in flight
  assign in_if.ready = (q_cnt_r + {{QAW{1'b0}}, s1_v_r}) < (QAW+1)'(QDEPTH);
  assign in_acc   = in_if.valid && in_if.ready;
  assign rd_acc   = in_acc && (in_if.op == OP_READ);
  assign wr_acc   = in_acc && (in_if.op == OP_WRITE);
  assign tick_acc = in_acc && (in_if.op == OP_TICK) && run_r;

  // Decode the NVRAM window
  assign ram_off = in_if.addr - RAM_BASE;
  assign ram_hit = (in_if.addr >= RAM_BASE) && (in_if.addr < RAM_END) &&
                   (ram_off < 8'(NVRAM_BYTES));
  assign ram_idx = ram_off[RAM_AW-1:0];

  // Advance the calendar by one second
  always_comb begin
    sec_inc  = sec_r + 8'd1;
    min_inc  = min_r + 8'd1;
    hour_inc = hour_r + 8'd1;
    wday_inc = wday_r + 8'd1;
    day_inc  = day_r + 8'd1;
    mon_inc  = mon_r + 8'd1;
    year_inc = year_r + 8'd1;
    ns_sec  = sec_r;
    ns_min  = min_r;
    ns_hour = hour_r;
    ns_wday = wday_r;
    ns_day  = day_r;
    ns_mon  = mon_r;
    ns_year = year_r;
    if (sec_inc < 8'd60) begin
      ns_sec = sec_inc;
    end else begin
      ns_sec = 8'd0;
      if (min_inc < 8'd60) begin
        ns_min = min_inc;
      end else begin
        ns_min = 8'd0;
        if (hour_inc < 8'd24) begin
          ns_hour = hour_inc;
        end else begin
          ns_hour = 8'd0;
          ns_wday = (wday_inc > 8'd7) ? 8'd1 : wday_inc;
          if (day_inc <= month_days(mon_r, year_r[1:0] == 2'd0)) begin
            ns_day = day_inc;
          end else begin
            ns_day = 8'd1;
            if (mon_inc <= 8'd12) begin
              ns_mon = mon_inc;
            end else begin
              ns_mon  = 8'd1;
              ns_year = (year_inc == 8'd100) ? 8'd0 : year_inc;
            end
          end
        end
      end
    end
  end

  // Add elapsed cycles, saturate, and take one second off when due
  assign pre_sum  = {1'b0, pre_r} + (PRE_W+1)'(in_if.cycles);
  assign pre_sat  = pre_sum[PRE_W] ? PRESCALE_MAX : pre_sum[PRE_W-1:0];
  assign pre_diff = {1'b0, pre_sat} - (PRE_W+1)'(tps_r);
  assign roll     = !pre_diff[PRE_W];

  // Decode an hour write in twelve-hour or 24-hour form
  always_comb begin
    wr_pm   = in_if.wdata[6] && in_if.wdata[5];
    wr_hour = in_if.wdata[6] ? from_bcd({3'd0, in_if.wdata[4:0]})
                             : from_bcd({2'd0, in_if.wdata[5:0]});
    if (in_if.wdata[6] && (wr_hour == 8'd12)) begin
      wr_hour = 8'd0;
    end
    if (wr_pm) begin
      wr_hour = wr_hour + 8'd12;
    end
  end

  // Update time registers for ticks and writes
  always_comb begin
    pre_nxt  = pre_r;
    run_nxt  = run_r;
    m24_nxt  = m24_r;
    bat_nxt  = bat_r;
    sec_nxt  = sec_r;
    min_nxt  = min_r;
    hour_nxt = hour_r;
    wday_nxt = wday_r;
    day_nxt  = day_r;
    mon_nxt  = mon_r;
    year_nxt = year_r;
    if (tick_acc) begin
      pre_nxt = roll ? pre_diff[PRE_W-1:0] : pre_sat;
      if (roll) begin
        sec_nxt  = ns_sec;
        min_nxt  = ns_min;
        hour_nxt = ns_hour;
        wday_nxt = ns_wday;
        day_nxt  = ns_day;
        mon_nxt  = ns_mon;
        year_nxt = ns_year;
      end
    end else if (wr_acc) begin
      unique case (in_if.addr)
        REG_SEC: begin
          run_nxt = in_if.wdata[7];
          sec_nxt = from_bcd({1'b0, in_if.wdata[6:0]});
        end
        REG_MIN:   min_nxt = from_bcd(in_if.wdata);
        REG_HOUR: begin
          m24_nxt  = !in_if.wdata[6];
          hour_nxt = wr_hour;
        end
        REG_WDAY: begin
          wday_nxt = {5'd0, in_if.wdata[2:0]};
          bat_nxt  = in_if.wdata[3];
        end
        REG_DAY:   day_nxt  = from_bcd(in_if.wdata);
        REG_MONTH: mon_nxt  = from_bcd(in_if.wdata);
        REG_YEAR:  year_nxt = from_bcd(in_if.wdata);
        default: ;
      endcase
    end
  end

  // Form the hour for reading
  always_comb begin
    hr_v  = hour_r;
    hr_pm = 1'b0;
    if (!m24_r) begin
      if (hr_v >= 8'd12) begin
        hr_pm = 1'b1;
        hr_v  = hr_v - 8'd12;
      end
      if (hr_v == 8'd0) begin
        hr_v = 8'd12;
      end
    end
  end

  // Select the read byte for register addresses
  always_comb begin
    unique case (in_if.addr)
      REG_SEC:   rd_byte = to_bcd(sec_r) | {run_r, 7'd0};
      REG_MIN:   rd_byte = to_bcd(min_r);
      REG_HOUR:  rd_byte = to_bcd(hr_v) | {1'b0, !m24_r, hr_pm, 5'd0};
      REG_WDAY:  rd_byte = wday_r | {2'd0, run_r, 1'b0, bat_r, 3'd0};
      REG_DAY:   rd_byte = to_bcd(day_r);
      REG_MONTH: rd_byte = to_bcd(mon_r) | {2'd0, year_r[1:0] == 2'd0, 5'd0};
      REG_YEAR:  rd_byte = to_bcd(year_r);
      default:   rd_byte = (in_if.addr >= RAM_END) ? 8'hFF : 8'h00;
    endcase
  end

  // Hold the time state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r  <= TPS_RESET;
      pre_r  <= '0;
      run_r  <= 1'b0;
      m24_r  <= 1'b1;
      bat_r  <= 1'b1;
      sec_r  <= 8'd0;
      min_r  <= 8'd0;
      hour_r <= 8'd0;
      wday_r <= 8'd1;
      day_r  <= 8'd1;
      mon_r  <= 8'd1;
      year_r <= 8'd0;
    end else begin
      if (cfg_we) begin
        tps_r <= cfg_wdata;
      end
      pre_r  <= pre_nxt;
      run_r  <= run_nxt;
      m24_r  <= m24_nxt;
      bat_r  <= bat_nxt;
      sec_r  <= sec_nxt;
      min_r  <= min_nxt;
      hour_r <= hour_nxt;
      wday_r <= wday_nxt;
      day_r  <= day_nxt;
      mon_r  <= mon_nxt;
      year_r <= year_nxt;
    end
  end

  // NVRAM: one write or one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_acc && ram_hit) begin
      ram_mem[ram_idx] <= in_if.wdata;
    end
    if (rd_acc && ram_hit) begin
      ram_q_r <= ram_mem[ram_idx];
    end
  end

  // Mark written NVRAM bytes; unwritten ones read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ram_vld_r <= '0;
    end else if (wr_acc && ram_hit) begin
      ram_vld_r[ram_idx] <= 1'b1;
    end
  end

  // Carry a read across the memory latency
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= rd_acc;
    end
    if (rd_acc) begin
      s1_r.is_ram <= ram_hit;
      s1_r.ram_ok <= ram_vld_r[ram_idx];
      s1_r.data   <= rd_byte;
    end
  end

  assign push_data = s1_r.is_ram ? (s1_r.ram_ok ? ram_q_r : 8'h00) : s1_r.data;

  // Queue results for the receiver
  assign push = s1_v_r;
  assign pop  = out_if.valid && out_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wp_r  <= '0;
      q_rp_r  <= '0;
      q_cnt_r <= '0;
    end else begin
      if (push) begin
        q_wp_r <= q_wp_r + 1'b1;
      end
      if (pop) begin
        q_rp_r <= q_rp_r + 1'b1;
      end
      q_cnt_r <= q_cnt_r + {{QAW{1'b0}}, push} - {{QAW{1'b0}}, pop};
    end
    if (push) begin
      q_mem_r[q_wp_r] <= push_data;
    end
  end

  assign out_if.valid = (q_cnt_r != '0);
  assign out_if.rdata = q_mem_r[q_rp_r];

endmodule

// File: hw/rtl/bcdrtc_checker.sv
module bcdrtc_checker
  import bcdrtc_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] in_op,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_rdata
);

  logic rd_acc;
  assign rd_acc = in_valid && in_ready && (in_op == OP_READ);

  // A read result is always on offer once the read has passed the read stage and the queue
  a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
    rd_acc |-> ##2 out_valid)
    else $error("read item gave no result two cycles later");

  // Results come only from reads
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid && !$past(rd_acc)) |=> !out_valid)
    else $error("result item without a read");

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_rdata)))
    else $error("stalled result item changed or dropped");

endmodule

bind bcd_rtc_calendar_registers_core bcdrtc_checker u_bcdrtc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .in_op     (in_if.op),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_rdata (out_if.rdata)
);

// File: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import bcdrtc_pkg::*;

  localparam logic [1:0] OP_NONE = 2'd3;
  localparam int RESULT_LATENCY = 2;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 200;
  localparam int PHASE_ITEMS = 180;
  localparam int PRESSURE_ITEMS = 60;
  localparam int HEAVY_PCT = 86;
  localparam int MIXED_PCT = 37;
  localparam logic [7:0] MONTH_LEN [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  typedef enum int {IDLE_NONE, IDLE_SOURCE, IDLE_SINK, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  addr;
    logic [7:0]  wdata;
    logic [15:0] cycles;
  } rtc_item_t;

  typedef struct packed {
    logic             is_rate;
    logic [TPS_W-1:0] rate;
    rtc_item_t        item;
    logic             known;
    logic [7:0]       rdata;
  } step_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [TPS_W-1:0] cfg_wdata;

  bcdrtc_in_if  in_if ();
  bcdrtc_out_if out_if ();

  bcd_rtc_calendar_registers_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .out_if    (out_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  // Calendar state mirrored by the predictor
  logic [PRE_W-1:0] cal_prescale;
  logic [TPS_W-1:0] cal_rate;
  logic             cal_run, cal_24h, cal_batt;
  logic [7:0]       cal_sec, cal_min, cal_hour, cal_wday, cal_day, cal_month, cal_year;
  logic [7:0]       cal_nvram [NVRAM_BYTES];

  logic [7:0] rdata_due [$];
  int         mismatch_count = 0;
  int         items_sent = 0;
  int         stall_cycles = 0;
  int         source_idle_pct = 0;
  int         sink_stall_pct = 0;
  bit         hold_request = 1'b0;
  logic       note_known;
  logic [7:0] note_rdata;

  function automatic logic [7:0] bin_to_bcd(input logic [7:0] v);
    int q;
    q = int'(v) / 10;
    return 8'((q << 4) | (int'(v) % 10));
  endfunction

  function automatic logic [7:0] bcd_to_bin(input logic [7:0] v);
    return 8'((int'(v) >> 4) * 10 + (int'(v) & 15));
  endfunction

  function automatic void reset_calendar();
    cal_prescale = '0;
    cal_rate = TPS_RESET;
    cal_run = 1'b0;
    cal_24h = 1'b1;
    cal_batt = 1'b1;
    cal_sec = 8'd0;
    cal_min = 8'd0;
    cal_hour = 8'd0;
    cal_wday = 8'd1;
    cal_day = 8'd1;
    cal_month = 8'd1;
    cal_year = 8'd0;
    foreach (cal_nvram[i]) cal_nvram[i] = 8'd0;
  endfunction

  // Carry one second through the whole calendar
  function automatic void advance_second();
    logic [7:0] mlen;
    cal_sec = cal_sec + 8'd1;
    if (cal_sec < 8'd60) return;
    cal_sec = 8'd0;
    cal_min = cal_min + 8'd1;
    if (cal_min < 8'd60) return;
    cal_min = 8'd0;
    cal_hour = cal_hour + 8'd1;
    if (cal_hour < 8'd24) return;
    cal_hour = 8'd0;
    cal_wday = cal_wday + 8'd1;
    if (cal_wday > 8'd7) cal_wday = 8'd1;
    cal_day = cal_day + 8'd1;
    if (cal_month >= 8'd1 && cal_month <= 8'd12) begin
      mlen = MONTH_LEN[cal_month - 8'd1];
      if (cal_month == 8'd2 && cal_year[1:0] == 2'b00) mlen = mlen + 8'd1;
    end else begin
      mlen = 8'd31;
    end
    if (cal_day <= mlen) return;
    cal_day = 8'd1;
    cal_month = cal_month + 8'd1;
    if (cal_month <= 8'd12) return;
    cal_month = 8'd1;
    cal_year = cal_year + 8'd1;
    if (cal_year == 8'd100) cal_year = 8'd0;
  endfunction

  function automatic logic [7:0] read_register(input logic [7:0] a);
    logic [7:0] h;
    logic       pm;
    int         idx;
    pm = 1'b0;
    idx = int'(a) - int'(RAM_BASE);
    case (a)
      REG_SEC:   return bin_to_bcd(cal_sec) | {cal_run, 7'd0};
      REG_MIN:   return bin_to_bcd(cal_min);
      REG_HOUR: begin
        h = cal_hour;
        if (!cal_24h) begin
          if (h >= 8'd12) begin
            pm = 1'b1;
            h = h - 8'd12;
          end
          if (h == 8'd0) h = 8'd12;
        end
        return bin_to_bcd(h) | {1'b0, !cal_24h, pm, 5'd0};
      end
      REG_WDAY:  return cal_wday | {2'b00, cal_run, 1'b0, cal_batt, 3'd0};
      REG_DAY:   return bin_to_bcd(cal_day);
      REG_MONTH: return bin_to_bcd(cal_month) | {2'b00, cal_year[1:0] == 2'b00, 5'd0};
      REG_YEAR:  return bin_to_bcd(cal_year);
      default: begin
        if (a >= RAM_BASE && a < RAM_END) return (idx < NVRAM_BYTES) ? cal_nvram[idx] : 8'd0;
        return (a >= RAM_END) ? 8'hFF : 8'h00;
      end
    endcase
  endfunction

  function automatic void write_register(input logic [7:0] a, input logic [7:0] v);
    logic [7:0] h;
    logic       pm;
    int         idx;
    pm = 1'b0;
    idx = int'(a) - int'(RAM_BASE);
    case (a)
      REG_SEC: begin
        cal_run = v[7];
        cal_sec = bcd_to_bin({1'b0, v[6:0]});
      end
      REG_MIN: cal_min = bcd_to_bin(v);
      REG_HOUR: begin
        cal_24h = !v[6];
        h = {2'b00, v[5:0]};
        if (!cal_24h) begin
          pm = v[5];
          h = {3'b000, v[4:0]};
        end
        h = bcd_to_bin(h);
        if (!cal_24h && h == 8'd12) h = 8'd0;
        if (pm) h = h + 8'd12;
        cal_hour = h;
      end
      REG_WDAY: begin
        cal_wday = {5'd0, v[2:0]};
        cal_batt = v[3];
      end
      REG_DAY:   cal_day = bcd_to_bin(v);
      REG_MONTH: cal_month = bcd_to_bin(v);
      REG_YEAR:  cal_year = bcd_to_bin(v);
      default: begin
        if (a >= RAM_BASE && a < RAM_END && idx < NVRAM_BYTES) cal_nvram[idx] = v;
      end
    endcase
  endfunction

  // Update the calendar for a tick or a write; reads leave it alone
  function automatic void apply_item(input rtc_item_t it);
    logic [PRE_W:0] sum;
    case (it.op)
      OP_TICK: begin
        if (cal_run) begin
          sum = {1'b0, cal_prescale} + {{(PRE_W - 15){1'b0}}, it.cycles};
          if (sum > {1'b0, PRESCALE_MAX}) sum = {1'b0, PRESCALE_MAX};
          cal_prescale = sum[PRE_W-1:0];
          if (cal_prescale >= {1'b0, cal_rate}) begin
            cal_prescale = cal_prescale - {1'b0, cal_rate};
            advance_second();
          end
        end
      end
      OP_WRITE: write_register(it.addr, it.wdata);
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    mismatch_count++;
  endtask

  // Score results first, then record what an accepted item will produce
  always @(posedge clk) begin
    logic [7:0] want;
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        if (rdata_due.size() == 0) begin
          report_mismatch($sformatf("read data %02h with no read pending", out_if.rdata));
        end else begin
          want = rdata_due.pop_front();
          if (out_if.rdata !== want)
            report_mismatch($sformatf("rdata %02h, want %02h", out_if.rdata, want));
        end
      end
      if (in_if.valid && in_if.ready) begin
        if (in_if.op == OP_READ)
          rdata_due.push_back(note_known ? note_rdata : read_register(in_if.addr));
        apply_item({in_if.op, in_if.addr, in_if.wdata, in_if.cycles});
      end
    end
  end

  // Abort when the block stops moving items
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Result side: random stalls, or a long hold when asked
  initial begin
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        repeat (HOLD_CYCLES) begin
          out_if.ready <= 1'b0;
          @(posedge clk);
        end
      end else begin
        out_if.ready <= ($urandom_range(99) >= sink_stall_pct);
        @(posedge clk);
      end
    end
  end

  function automatic rtc_item_t make_item(input logic [1:0] op, input logic [7:0] addr,
                                          input logic [7:0] wdata, input logic [15:0] cycles);
    rtc_item_t it;
    it.op = op;
    it.addr = addr;
    it.wdata = wdata;
    it.cycles = cycles;
    return it;
  endfunction

  function automatic step_row_t item_row(input logic [1:0] op, input logic [7:0] addr,
                                         input logic [7:0] wdata, input logic [15:0] cycles,
                                         input logic known = 1'b0,
                                         input logic [7:0] rdata = 8'h00);
    step_row_t r;
    r = '0;
    r.item = make_item(op, addr, wdata, cycles);
    r.known = known;
    r.rdata = rdata;
    return r;
  endfunction

  function automatic step_row_t rate_row(input logic [TPS_W-1:0] v);
    step_row_t r;
    r = '0;
    r.is_rate = 1'b1;
    r.rate = v;
    return r;
  endfunction

  function automatic void set_idling(input idle_mode_t mode);
    case (mode)
      IDLE_SOURCE: begin source_idle_pct = HEAVY_PCT; sink_stall_pct = 0; end
      IDLE_SINK:   begin source_idle_pct = 0; sink_stall_pct = HEAVY_PCT; end
      IDLE_BOTH:   begin source_idle_pct = MIXED_PCT; sink_stall_pct = MIXED_PCT; end
      default:     begin source_idle_pct = 0; sink_stall_pct = 0; end
    endcase
  endfunction

  function automatic logic [7:0] pick_addr();
    case ($urandom_range(3))
      0, 1:    return 8'($urandom_range(7));
      2:       return 8'($urandom_range(int'(RAM_BASE), int'(RAM_END) - 1));
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_cycles();
    int lim;
    lim = (cal_rate > 27'd65535) ? 65535 : int'(cal_rate);
    case ($urandom_range(3))
      0:       return 16'($urandom);
      1:       return 16'(lim);
      2:       return 16'($urandom_range(lim));
      default: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
    endcase
  endfunction

  // Offer one item, with random idle cycles ahead of it, and hold it until taken
  task automatic send_item(input rtc_item_t it, input logic known = 1'b0,
                           input logic [7:0] rdata = 8'h00);
    while (source_idle_pct != 0 && $urandom_range(99) < source_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid  <= 1'b1;
    in_if.op     <= it.op;
    in_if.addr   <= it.addr;
    in_if.wdata  <= it.wdata;
    in_if.cycles <= it.cycles;
    note_known   <= known;
    note_rdata   <= rdata;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    items_sent++;
  endtask

  // Stop offering and let every pending read come back
  task automatic drain_all();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (rdata_due.size() != 0) @(posedge clk);
    repeat (RESULT_LATENCY + 2) @(posedge clk);
  endtask

  task automatic load_rate(input logic [TPS_W-1:0] v);
    drain_all();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cal_rate = v;
  endtask

  // Set the clock near a rollover, run it for a few ticks, read it back
  task automatic clock_sequence();
    logic [7:0] v;
    int         n;
    if ($urandom_range(99) < 60) begin
      case ($urandom_range(9))
        0, 1, 2: v = bin_to_bcd(8'd99);
        3:       v = 8'($urandom);
        default: v = bin_to_bcd(8'($urandom_range(99)));
      endcase
      send_item(make_item(OP_WRITE, REG_YEAR, v, 16'($urandom)));
    end
    if ($urandom_range(99) < 60) begin
      case ($urandom_range(9))
        0, 1, 2: v = bin_to_bcd(8'd2);
        3, 4, 5: v = bin_to_bcd(8'd12);
        6:       v = 8'($urandom);
        7:       v = 8'h00;
        default: v = bin_to_bcd(8'($urandom_range(1, 12)));
      endcase
      send_item(make_item(OP_WRITE, REG_MONTH, v, 16'($urandom)));
    end
    if ($urandom_range(99) < 60) begin
      v = ($urandom_range(9) != 0) ? bin_to_bcd(8'($urandom_range(27, 31))) : 8'($urandom);
      send_item(make_item(OP_WRITE, REG_DAY, v, 16'($urandom)));
    end
    if ($urandom_range(99) < 50)
      send_item(make_item(OP_WRITE, REG_WDAY, 8'($urandom), 16'($urandom)));
    if ($urandom_range(99) < 60) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: v = bin_to_bcd(8'($urandom_range(21, 23)));
        6:                v = 8'($urandom);
        default: v = 8'h40 | {2'b00, 1'($urandom), 5'd0} | bin_to_bcd(8'($urandom_range(1, 12)));
      endcase
      send_item(make_item(OP_WRITE, REG_HOUR, v, 16'($urandom)));
    end
    if ($urandom_range(99) < 60) begin
      v = ($urandom_range(9) != 0) ? bin_to_bcd(8'($urandom_range(57, 59))) : 8'($urandom);
      send_item(make_item(OP_WRITE, REG_MIN, v, 16'($urandom)));
    end
    // Seconds carry the run bit, so this write starts or stops the clock
    if ($urandom_range(6) != 0) begin
      v = bin_to_bcd(8'($urandom_range(55, 59)));
      v[7] = ($urandom_range(9) != 0);
    end else begin
      v = 8'($urandom);
    end
    send_item(make_item(OP_WRITE, REG_SEC, v, 16'($urandom)));
    n = $urandom_range(1, 10);
    repeat (n) send_item(make_item(OP_TICK, 8'($urandom), 8'($urandom), pick_cycles()));
    for (int r = 0; r <= int'(REG_YEAR); r++) begin
      if ($urandom_range(9) < 7)
        send_item(make_item(OP_READ, 8'(r), 8'($urandom), 16'($urandom)));
    end
  endtask

  // Fill a few NVRAM bytes and read some of them back
  task automatic nvram_sequence();
    logic [7:0] a [4];
    foreach (a[i]) begin
      a[i] = 8'($urandom_range(int'(RAM_BASE), int'(RAM_END) - 1));
      send_item(make_item(OP_WRITE, a[i], 8'($urandom), 16'($urandom)));
    end
    foreach (a[i]) begin
      if ($urandom_range(3) != 0)
        send_item(make_item(OP_READ, a[i], 8'($urandom), 16'($urandom)));
    end
    send_item(make_item(OP_READ, pick_addr(), 8'($urandom), 16'($urandom)));
  endtask

  task automatic run_random(input int count);
    int target;
    int pick;
    target = items_sent + count;
    while (items_sent < target) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        clock_sequence();
      end else if (pick < 80) begin
        nvram_sequence();
      end else begin
        repeat ($urandom_range(1, 6))
          send_item(make_item(2'($urandom), pick_addr(), 8'($urandom), 16'($urandom)));
      end
    end
  endtask

  initial begin
    step_row_t        rows [$];
    logic [TPS_W-1:0] phase_rate [8];

    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_wdata    <= '0;
    in_if.valid  <= 1'b0;
    in_if.op     <= OP_TICK;
    in_if.addr   <= 8'h00;
    in_if.wdata  <= 8'h00;
    in_if.cycles <= 16'h0000;
    note_known   <= 1'b0;
    note_rdata   <= 8'h00;
    reset_calendar();

    // Reset values, unused and NVRAM addresses, stopped clock, unknown op
    rows.push_back(item_row(OP_READ, REG_SEC, 8'h00, 16'h0000, 1'b1, 8'h00));
    rows.push_back(item_row(OP_READ, REG_HOUR, 8'hFF, 16'hFFFF, 1'b1, 8'h00));
    rows.push_back(item_row(OP_READ, REG_WDAY, 8'h00, 16'h0000, 1'b1, 8'h09));
    rows.push_back(item_row(OP_READ, REG_MONTH, 8'h00, 16'h0000, 1'b1, 8'h21));
    rows.push_back(item_row(OP_READ, 8'h07, 8'h00, 16'h0000, 1'b1, 8'h00));
    rows.push_back(item_row(OP_READ, RAM_END, 8'h00, 16'h0000, 1'b1, 8'hFF));
    rows.push_back(item_row(OP_READ, RAM_BASE, 8'h00, 16'h0000, 1'b1, 8'h00));
    rows.push_back(item_row(OP_TICK, 8'h00, 8'h00, 16'hFFFF));
    rows.push_back(item_row(OP_NONE, 8'h5F, 8'hFF, 16'hFFFF));
    rows.push_back(item_row(OP_WRITE, 8'h5F, 8'hA5, 16'h0000));
    rows.push_back(item_row(OP_WRITE, 8'hFF, 8'h5A, 16'h0000));
    rows.push_back(item_row(OP_READ, 8'h5F, 8'h00, 16'h0000, 1'b1, 8'hA5));
    // Zero rate: a full tick moves one second across the year end
    // from an odd month, in twelve hour mode
    rows.push_back(rate_row('0));
    rows.push_back(item_row(OP_WRITE, REG_YEAR, 8'h99, 16'h0000));
    rows.push_back(item_row(OP_WRITE, REG_MONTH, 8'h13, 16'h0000));
    rows.push_back(item_row(OP_WRITE, REG_DAY, 8'h31, 16'h0000));
    rows.push_back(item_row(OP_WRITE, REG_HOUR, 8'h71, 16'h0000));
    rows.push_back(item_row(OP_WRITE, REG_MIN, 8'h59, 16'h0000));
    rows.push_back(item_row(OP_WRITE, REG_SEC, 8'hD9, 16'h0000));
    rows.push_back(item_row(OP_TICK, 8'h00, 8'h00, 16'hFFFF));
    rows.push_back(item_row(OP_READ, REG_HOUR, 8'h00, 16'h0000));
    rows.push_back(item_row(OP_READ, REG_MONTH, 8'h00, 16'h0000));
    rows.push_back(item_row(OP_READ, REG_YEAR, 8'h00, 16'h0000));
    rows.push_back(item_row(OP_READ, REG_SEC, 8'h00, 16'h0000));
    // Non-BCD write and its read back
    rows.push_back(item_row(OP_WRITE, REG_MIN, 8'hFF, 16'h0000));
    rows.push_back(item_row(OP_READ, REG_MIN, 8'h00, 16'h0000));
    rows.push_back(item_row(OP_READ, 8'hFF, 8'h00, 16'h0000, 1'b1, 8'hFF));

    phase_rate = '{TPS_RESET, 27'd1, 27'($urandom_range(2, 40)), 27'd0, 27'd100000000,
                   27'($urandom_range(1000, 70000)), 27'd3, 27'($urandom_range(41, 5000))};

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table
    set_idling(IDLE_NONE);
    foreach (rows[i]) begin
      if (rows[i].is_rate) load_rate(rows[i].rate);
      else send_item(rows[i].item, rows[i].known, rows[i].rdata);
    end

    // Random phases across rates and idling patterns
    foreach (phase_rate[p]) begin
      load_rate(phase_rate[p]);
      set_idling(idle_mode_t'(p % 4));
      run_random(PHASE_ITEMS);
    end

    // Hold the result side while reads keep coming, then wait for all of them
    drain_all();
    set_idling(IDLE_NONE);
    hold_request = 1'b1;
    repeat (PRESSURE_ITEMS)
      send_item(make_item(OP_READ, pick_addr(), 8'($urandom), 16'($urandom)));
    drain_all();
    run_random(PHASE_ITEMS / 4);

    drain_all();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: bcd_rtc_calendar_registers_core.f
hw/rtl/bcdrtc_pkg.sv
hw/rtl/bcdrtc_in_if.sv
hw/rtl/bcdrtc_out_if.sv
hw/rtl/bcd_rtc_calendar_registers_core.sv
hw/rtl/bcdrtc_checker.sv
dv/testbench.sv
